FILE: hw/rtl/config_text_tokenizer_top_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef CONFIG_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds on every clock edge outside reset
`define CTT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds, post holds on the next clock edge
`define CTT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define CTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

FILE: hw/rtl/ctt_pkg.sv
`default_nettype none

package ctt_pkg;

	// Token kinds
	localparam logic [3:0] K_EOF   = 4'd0;
	localparam logic [3:0] K_ERR   = 4'd1;
	localparam logic [3:0] K_NL    = 4'd2;
	localparam logic [3:0] K_OPEN  = 4'd3;
	localparam logic [3:0] K_CLOSE = 4'd4;
	localparam logic [3:0] K_SLASH = 4'd5;
	localparam logic [3:0] K_STAR  = 4'd6;
	localparam logic [3:0] K_DOT   = 4'd7;
	localparam logic [3:0] K_INT   = 4'd8;
	localparam logic [3:0] K_TEXT  = 4'd9;
	localparam logic [3:0] K_TEND  = 4'd10;

	// Result queue between scanner and output stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One token result as it leaves the block
	typedef struct packed {
		logic [3:0]         kind;
		logic [7:0]         tbyte;
		logic signed [31:0] value;
		logic [15:0]        line;
		logic [15:0]        column;
	} ctt_result_t;

	// All results caused by one input item (one or two)
	typedef struct packed {
		logic        two;
		ctt_result_t r0;
		ctt_result_t r1;
	} ctt_bundle_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ctt_front.sv
`default_nettype none
`include "config_text_tokenizer_top_assert.svh"

module ctt_front #(
	parameter int POSITION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  logic [7:0]           char_byte,
	input  logic                 end_of_input,
	input  logic                 q_full,
	output logic                 q_push,
	output ctt_pkg::ctt_bundle_t q_data
);

	// Scanner modes
	localparam logic [3:0] M_IDLE       = 4'd0;
	localparam logic [3:0] M_IDLE_NB    = 4'd1;
	localparam logic [3:0] M_COMMENT    = 4'd2;
	localparam logic [3:0] M_NEWLINES   = 4'd3;
	localparam logic [3:0] M_SYMBOL     = 4'd4;
	localparam logic [3:0] M_MINUS      = 4'd5;
	localparam logic [3:0] M_DIGITS     = 4'd6;
	localparam logic [3:0] M_STRING     = 4'd7;
	localparam logic [3:0] M_BRACE      = 4'd8;
	localparam logic [3:0] M_BODY       = 4'd9;
	localparam logic [3:0] M_BODY_BRACE = 4'd10;
	localparam logic [3:0] M_ERROR      = 4'd11;

	// Characters
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;

	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	localparam logic [35:0] SAT_MAG = 36'h080000000;

	logic [3:0]               mode_q;
	logic [31:0]              acc_q;
	logic                     neg_q;
	logic                     ntext_q;
	logic                     numbers_as_text_q;
	logic [POSITION_BITS-1:0] cur_line_q;
	logic [POSITION_BITS-1:0] cur_col_q;
	logic [POSITION_BITS-1:0] st_line_q;
	logic [POSITION_BITS-1:0] st_col_q;

	logic       accept;
	logic [7:0] c;
	logic       is_blank;
	logic       is_letter;
	logic       is_digit;
	logic       is_sym;
	logic       is_minus;
	logic [3:0] digit;

	logic        st_emit;
	logic [3:0]  st_kind;
	logic [7:0]  st_byte;
	logic [3:0]  st_mode;

	logic [35:0] acc_x10;
	logic [31:0] acc_sat;
	logic [3:0]  fin_kind;
	logic [31:0] fin_val;

	logic [3:0]  mode_d;
	logic        a_v;
	logic [3:0]  a_kind;
	logic [7:0]  a_byte;
	logic [31:0] a_val;
	logic        b_v;
	logic [3:0]  b_kind;
	logic [7:0]  b_byte;
	logic        b_at_cur;
	logic        do_start;
	logic        num_first;
	logic        num_add;
	logic        pos_step;
	logic        pos_clear;

	ctt_pkg::ctt_result_t res_a;
	ctt_pkg::ctt_result_t res_b;

	assign c          = char_byte;
	assign char_stall = q_full;
	assign accept     = char_valid && !char_stall;

	// Character classes
	assign is_blank  = (c == CH_SPACE) || (c == CH_TAB);
	assign is_letter = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	assign is_digit  = c inside {[CH_ZERO:CH_NINE]};
	assign is_sym    = is_letter || is_digit || (c == CH_UNDER) || (c == CH_MINUS);
	assign is_minus  = (c == CH_MINUS);
	assign digit     = c[3:0];

	// Decimal accumulate, saturating at the magnitude of the most negative value
	assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, digit};
	assign acc_sat = (acc_x10 > SAT_MAG) ? 32'h80000000 : acc_x10[31:0];

	// Integer close: digit text end or the converted value
	always_comb begin
		fin_kind = ntext_q ? ctt_pkg::K_TEND : ctt_pkg::K_INT;
		if (ntext_q)
			fin_val = 32'd0;
		else if (neg_q)
			fin_val = 32'd0 - acc_q;
		else
			fin_val = acc_q[31] ? 32'h7FFFFFFF : acc_q;
	end

	// What a byte does when it opens a new token
	always_comb begin
		st_emit = 1'b0;
		st_kind = ctt_pkg::K_ERR;
		st_byte = 8'd0;
		st_mode = M_IDLE;
		if (is_blank) begin
			if (mode_q == M_IDLE_NB) begin
				st_emit = 1'b1;
				st_mode = M_ERROR;
			end
		end else if (c == CH_HASH) begin
			st_mode = M_COMMENT;
		end else if (c == CH_SLASH) begin
			st_emit = 1'b1;
			st_kind = ctt_pkg::K_SLASH;
		end else if (c == CH_STAR) begin
			st_emit = 1'b1;
			st_kind = ctt_pkg::K_STAR;
		end else if (c == CH_DOT) begin
			st_emit = 1'b1;
			st_kind = ctt_pkg::K_DOT;
		end else if (c == CH_NL) begin
			st_mode = M_NEWLINES;
		end else if (is_letter) begin
			st_emit = 1'b1;
			st_kind = ctt_pkg::K_TEXT;
			st_byte = c;
			st_mode = M_SYMBOL;
		end else if (is_digit) begin
			st_emit = numbers_as_text_q;
			st_kind = ctt_pkg::K_TEXT;
			st_byte = c;
			st_mode = M_DIGITS;
		end else if (is_minus) begin
			st_mode = M_MINUS;
		end else if (c == CH_OPEN) begin
			st_mode = M_BRACE;
		end else if (c == CH_QUOTE) begin
			st_mode = M_STRING;
		end else begin
			st_emit = 1'b1;
			st_mode = M_ERROR;
		end
	end

	// Scanner: result A continues or closes the running token, result B is the next one or end of input
	always_comb begin
		mode_d    = mode_q;
		a_v       = 1'b0;
		a_kind    = ctt_pkg::K_EOF;
		a_byte    = 8'd0;
		a_val     = 32'd0;
		b_v       = 1'b0;
		b_kind    = ctt_pkg::K_EOF;
		b_byte    = 8'd0;
		b_at_cur  = 1'b1;
		do_start  = 1'b0;
		num_first = 1'b0;
		num_add   = 1'b0;
		pos_step  = 1'b0;
		pos_clear = 1'b0;
		if (mode_q != M_ERROR) begin
			if (end_of_input) begin
				case (mode_q)
					M_NEWLINES: begin
						a_v    = 1'b1;
						a_kind = ctt_pkg::K_NL;
					end
					M_SYMBOL, M_STRING: begin
						a_v    = 1'b1;
						a_kind = ctt_pkg::K_TEND;
					end
					M_DIGITS: begin
						a_v    = 1'b1;
						a_kind = fin_kind;
						a_val  = fin_val;
					end
					M_MINUS, M_BRACE, M_BODY, M_BODY_BRACE: begin
						a_v    = 1'b1;
						a_kind = ctt_pkg::K_ERR;
						mode_d = M_ERROR;
					end
					default: ;
				endcase
				if (mode_d != M_ERROR) begin
					b_v       = 1'b1;
					b_kind    = ctt_pkg::K_EOF;
					mode_d    = M_IDLE;
					pos_clear = 1'b1;
				end
			end else begin
				pos_step = 1'b1;
				case (mode_q)
					M_COMMENT: begin
						if (c == CH_NL)
							mode_d = M_IDLE_NB;
					end
					M_NEWLINES: begin
						if (c != CH_NL) begin
							a_v      = 1'b1;
							a_kind   = ctt_pkg::K_NL;
							do_start = 1'b1;
						end
					end
					M_SYMBOL: begin
						a_v = 1'b1;
						if (is_sym) begin
							a_kind = ctt_pkg::K_TEXT;
							a_byte = c;
						end else begin
							a_kind   = ctt_pkg::K_TEND;
							do_start = 1'b1;
						end
					end
					M_MINUS: begin
						if (is_digit) begin
							num_first = 1'b1;
							a_v       = numbers_as_text_q;
							a_kind    = ctt_pkg::K_TEXT;
							a_byte    = c;
							mode_d    = M_DIGITS;
						end else begin
							a_v    = 1'b1;
							a_kind = ctt_pkg::K_ERR;
							mode_d = M_ERROR;
						end
					end
					M_DIGITS: begin
						if (is_digit) begin
							num_add = 1'b1;
							a_v     = ntext_q;
							a_kind  = ctt_pkg::K_TEXT;
							a_byte  = c;
						end else begin
							a_v      = 1'b1;
							a_kind   = fin_kind;
							a_val    = fin_val;
							do_start = 1'b1;
						end
					end
					M_STRING: begin
						a_v = 1'b1;
						if (c == CH_QUOTE) begin
							a_kind = ctt_pkg::K_TEND;
							mode_d = M_IDLE;
						end else begin
							a_kind = ctt_pkg::K_TEXT;
							a_byte = c;
						end
					end
					M_BRACE: begin
						a_v = 1'b1;
						if (c == CH_OPEN) begin
							a_kind = ctt_pkg::K_OPEN;
							mode_d = M_BODY;
						end else begin
							a_kind = ctt_pkg::K_ERR;
							mode_d = M_ERROR;
						end
					end
					M_BODY: begin
						if (c == CH_CLOSE) begin
							mode_d = M_BODY_BRACE;
						end else begin
							a_v    = 1'b1;
							a_kind = ctt_pkg::K_TEXT;
							a_byte = c;
						end
					end
					M_BODY_BRACE: begin
						a_v      = 1'b1;
						b_v      = 1'b1;
						b_at_cur = 1'b0;
						if (c == CH_CLOSE) begin
							a_kind = ctt_pkg::K_TEND;
							b_kind = ctt_pkg::K_CLOSE;
							mode_d = M_IDLE;
						end else begin
							// single close brace inside a body is text
							a_kind = ctt_pkg::K_TEXT;
							a_byte = CH_CLOSE;
							b_kind = ctt_pkg::K_TEXT;
							b_byte = c;
							mode_d = M_BODY;
						end
					end
					default: do_start = 1'b1;
				endcase
				if (do_start) begin
					mode_d = st_mode;
					b_v    = st_emit;
					b_kind = st_kind;
					b_byte = st_byte;
				end
			end
		end
	end

	// Results with their start positions
	always_comb begin
		res_a.kind   = a_kind;
		res_a.tbyte  = a_byte;
		res_a.value  = a_val;
		res_a.line   = 16'(st_line_q);
		res_a.column = 16'(st_col_q);
		res_b.kind   = b_kind;
		res_b.tbyte  = b_byte;
		res_b.value  = 32'sd0;
		res_b.line   = b_at_cur ? 16'(cur_line_q) : 16'(st_line_q);
		res_b.column = b_at_cur ? 16'(cur_col_q) : 16'(st_col_q);
	end

	assign q_push     = accept && (a_v || b_v);
	assign q_data.two = a_v && b_v;
	assign q_data.r0  = a_v ? res_a : res_b;
	assign q_data.r1  = res_b;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numbers_as_text_q <= 1'b0;
		end else if (cfg_we) begin
			numbers_as_text_q <= cfg_data;
		end
	end

	// Scanner state and number accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			acc_q   <= 32'd0;
			neg_q   <= 1'b0;
			ntext_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			if (num_first || (do_start && is_digit)) begin
				acc_q   <= {28'd0, digit};
				ntext_q <= numbers_as_text_q;
			end
			if (do_start && is_digit)
				neg_q <= 1'b0;
			if (do_start && is_minus) begin
				neg_q <= 1'b1;
				acc_q <= 32'd0;
			end
			if (num_add)
				acc_q <= acc_sat;
		end
	end

	// Line and column tracking, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q <= POS_ONE;
			cur_col_q  <= POS_ONE;
			st_line_q  <= POS_ONE;
			st_col_q   <= POS_ONE;
		end else if (accept) begin
			if (pos_clear) begin
				cur_line_q <= POS_ONE;
				cur_col_q  <= POS_ONE;
				st_line_q  <= POS_ONE;
				st_col_q   <= POS_ONE;
			end else if (pos_step) begin
				if (do_start) begin
					st_line_q <= cur_line_q;
					st_col_q  <= cur_col_q;
				end
				if (c == CH_NL) begin
					cur_col_q <= POS_ONE;
					if (cur_line_q != POS_MAX)
						cur_line_q <= cur_line_q + 1'b1;
				end else if (cur_col_q != POS_MAX) begin
					cur_col_q <= cur_col_q + 1'b1;
				end
			end
		end
	end

	`CTT_ASSERT_NEXT(a_err_sticky, clk, arst_n, mode_q == M_ERROR, mode_q == M_ERROR, "error not sticky")
	`CTT_ASSERT(a_err_quiet, clk, arst_n, (mode_q != M_ERROR) || !q_push, "result after error")

endmodule

`default_nettype wire

FILE: hw/rtl/ctt_queue.sv
`default_nettype none
`include "config_text_tokenizer_top_assert.svh"

module ctt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ctt_pkg::ctt_bundle_t push_data,
	output logic                 full,
	input  logic                 pop,
	output ctt_pkg::ctt_bundle_t head,
	output logic                 head_valid
);

	localparam int PW = ctt_pkg::QPTR_W;
	localparam logic [PW:0] CNT_FULL = (PW+1)'(ctt_pkg::QUEUE_DEPTH);

	ctt_pkg::ctt_bundle_t entries_q [ctt_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CTT_ASSERT(a_q_bound, clk, arst_n, count_q <= CNT_FULL, "queue count above depth")
	`CTT_ASSERT(a_q_pop_empty, clk, arst_n, !pop || head_valid, "pop from empty queue")
	`CTT_ASSERT(a_q_push_full, clk, arst_n, !push || !full, "push into full queue")

endmodule

`default_nettype wire

FILE: hw/rtl/ctt_back.sv
`default_nettype none
`include "config_text_tokenizer_top_assert.svh"

module ctt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  ctt_pkg::ctt_bundle_t q_head,
	output logic                 q_pop,
	output logic                 token_valid,
	input  logic                 token_stall,
	output logic [3:0]           token_kind,
	output logic [7:0]           text_byte,
	output logic signed [31:0]   int_value,
	output logic [15:0]          token_line,
	output logic [15:0]          token_column,
	output logic                 last
);

	logic                 token_valid_q;
	logic                 sel_q;
	logic                 load;
	logic                 more;
	ctt_pkg::ctt_result_t pick;
	ctt_pkg::ctt_result_t res_q;
	logic                 last_q;

	// Output register loads when empty or its transfer completes
	assign load  = q_valid && (!token_valid_q || !token_stall);
	assign more  = q_head.two && !sel_q;
	assign pick  = sel_q ? q_head.r1 : q_head.r0;
	assign q_pop = load && !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_q <= 1'b0;
			sel_q         <= 1'b0;
		end else if (load) begin
			token_valid_q <= 1'b1;
			sel_q         <= more;
		end else if (!token_stall) begin
			token_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= pick;
			last_q <= !more;
		end
	end

	assign token_valid  = token_valid_q;
	assign token_kind   = res_q.kind;
	assign text_byte    = res_q.tbyte;
	assign int_value    = res_q.value;
	assign token_line   = res_q.line;
	assign token_column = res_q.column;
	assign last         = last_q;

	`CTT_ASSERT(a_second_held, clk, arst_n, !sel_q || (q_valid && q_head.two), "second result lost")

endmodule

`default_nettype wire

FILE: hw/rtl/config_text_tokenizer_top.sv
// Channel   Signals                                   Direction
// char      char_valid, char_stall, char_byte,        in
//           end_of_input
// token     token_valid, token_stall, token_kind,     out
//           text_byte, int_value, token_line,
//           token_column, last
// config    numbers_as_text_we, numbers_as_text       in
//
// One item is taken per cycle while char_stall is low; the scanner state loop is registered.
// An item yields zero, one or two results; results leave at one per cycle through the
// output register while token_stall is low; an item with two results sends them in turn.
// First result is presented after its item's transfer, through the queue write, then the output load.
// A four-entry result queue decouples the sides; char_stall rises only when it is full.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none

module config_text_tokenizer_top #(
	parameter int POSITION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               numbers_as_text_we,
	input  logic               numbers_as_text,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_byte,
	input  logic               end_of_input,
	output logic               token_valid,
	input  logic               token_stall,
	output logic [3:0]         token_kind,
	output logic [7:0]         text_byte,
	output logic signed [31:0] int_value,
	output logic [15:0]        token_line,
	output logic [15:0]        token_column,
	output logic               last
);

	logic                 q_full;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_valid;
	ctt_pkg::ctt_bundle_t q_wdata;
	ctt_pkg::ctt_bundle_t q_head;

	// Scanner: accepts bytes, classifies, builds result bundles
	ctt_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (numbers_as_text_we),
		.cfg_data     (numbers_as_text),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	// Bundle queue
	ctt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_valid)
	);

	// Output serializer
	ctt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.text_byte    (text_byte),
		.int_value    (int_value),
		.token_line   (token_line),
		.token_column (token_column),
		.last         (last)
	);

endmodule

`default_nettype wire

FILE: tb/tb_config_text_tokenizer_top.sv
module tb_config_text_tokenizer_top;

	localparam int WATCHDOG_LIMIT = 400;
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// Scanner modes of the predictor
	typedef enum logic [3:0] {
		SCAN_IDLE,
		SCAN_IDLE_NB,
		SCAN_COMMENT,
		SCAN_NEWLINES,
		SCAN_SYMBOL,
		SCAN_MINUS,
		SCAN_DIGITS,
		SCAN_STRING,
		SCAN_BRACE,
		SCAN_BODY,
		SCAN_BODY_BRACE,
		SCAN_ERROR
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} char_item_t;

	typedef struct packed {
		logic [3:0]         kind;
		logic [7:0]         tbyte;
		logic signed [31:0] value;
		logic [15:0]        line;
		logic [15:0]        column;
		logic               last;
	} token_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               numbers_as_text_we = 1'b0;
	logic               numbers_as_text = 1'b0;
	logic               char_valid = 1'b0;
	logic               char_stall;
	logic [7:0]         char_byte = 8'h00;
	logic               end_of_input = 1'b0;
	logic               token_valid;
	logic               token_stall = 1'b0;
	logic [3:0]         token_kind;
	logic [7:0]         text_byte;
	logic signed [31:0] int_value;
	logic [15:0]        token_line;
	logic [15:0]        token_column;
	logic               last;

	config_text_tokenizer_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.numbers_as_text_we(numbers_as_text_we),
		.numbers_as_text   (numbers_as_text),
		.char_valid        (char_valid),
		.char_stall        (char_stall),
		.char_byte         (char_byte),
		.end_of_input      (end_of_input),
		.token_valid       (token_valid),
		.token_stall       (token_stall),
		.token_kind        (token_kind),
		.text_byte         (text_byte),
		.int_value         (int_value),
		.token_line        (token_line),
		.token_column      (token_column),
		.last              (last)
	);

	// Clock
	initial begin
		forever #6 clk = ~clk;
	end

	// Predictor state, matching the block after reset
	bit          text_mode = 1'b0;
	scan_mode_t  scan_state = SCAN_IDLE;
	logic [31:0] num_acc = 32'd0;
	logic        num_neg = 1'b0;
	logic        num_as_text = 1'b0;
	logic [15:0] cur_line = 16'd1;
	logic [15:0] cur_col = 16'd1;
	logic [15:0] tok_line = 16'd1;
	logic [15:0] tok_col = 16'd1;
	int          step_count;

	token_t      expected_tokens[$];
	char_item_t  pending_chars[$];
	char_item_t  next_item;
	token_t      exp_token;
	int          queued_items = 0;
	bit          after_comment = 1'b0;
	bit          gaps_on = 1'b1;
	int          send_gap = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	string       sym_chars =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Token result at the current token start
	task automatic push_token(input logic [3:0] kind, input logic [7:0] tb,
			input logic [31:0] value);
		token_t t;
		t.kind = kind;
		t.tbyte = tb;
		t.value = value;
		t.line = tok_line;
		t.column = tok_col;
		t.last = 1'b0;
		expected_tokens.push_back(t);
		step_count++;
	endtask

	task automatic raise_error();
		push_token(ctt_pkg::K_ERR, 8'h00, 32'd0);
		scan_state = SCAN_ERROR;
	endtask

	task automatic finish_number();
		if (num_as_text)
			push_token(ctt_pkg::K_TEND, 8'h00, 32'd0);
		else if (num_neg)
			push_token(ctt_pkg::K_INT, 8'h00, 32'd0 - num_acc);
		else
			push_token(ctt_pkg::K_INT, 8'h00,
				(num_acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_acc);
	endtask

	// First byte of a token; blanks are illegal right after a comment
	task automatic start_token(input logic [7:0] c, input bit no_blanks);
		tok_line = cur_line;
		tok_col = cur_col;
		scan_state = SCAN_IDLE;
		if (c == " " || c == "\t") begin
			if (no_blanks)
				raise_error();
		end else if (c == "#") begin
			scan_state = SCAN_COMMENT;
		end else if (c == "/") begin
			push_token(ctt_pkg::K_SLASH, 8'h00, 32'd0);
		end else if (c == "*") begin
			push_token(ctt_pkg::K_STAR, 8'h00, 32'd0);
		end else if (c == ".") begin
			push_token(ctt_pkg::K_DOT, 8'h00, 32'd0);
		end else if (c == "\n") begin
			scan_state = SCAN_NEWLINES;
		end else if (is_letter(c)) begin
			push_token(ctt_pkg::K_TEXT, c, 32'd0);
			scan_state = SCAN_SYMBOL;
		end else if (is_digit(c)) begin
			num_neg = 1'b0;
			num_acc = {24'd0, c - "0"};
			num_as_text = text_mode;
			if (num_as_text)
				push_token(ctt_pkg::K_TEXT, c, 32'd0);
			scan_state = SCAN_DIGITS;
		end else if (c == "-") begin
			num_neg = 1'b1;
			num_acc = 32'd0;
			scan_state = SCAN_MINUS;
		end else if (c == "{") begin
			scan_state = SCAN_BRACE;
		end else if (c == "\"") begin
			scan_state = SCAN_STRING;
		end else begin
			raise_error();
		end
	endtask

	// Expected tokens for one accepted transfer
	task automatic tokenize_step(input logic [7:0] c, input logic eoi);
		logic [63:0] wide;
		token_t t;
		step_count = 0;
		if (scan_state != SCAN_ERROR) begin
			if (eoi) begin
				case (scan_state)
					SCAN_MINUS, SCAN_BRACE, SCAN_BODY, SCAN_BODY_BRACE: raise_error();
					default: begin
						if (scan_state == SCAN_NEWLINES)
							push_token(ctt_pkg::K_NL, 8'h00, 32'd0);
						else if (scan_state == SCAN_SYMBOL || scan_state == SCAN_STRING)
							push_token(ctt_pkg::K_TEND, 8'h00, 32'd0);
						else if (scan_state == SCAN_DIGITS)
							finish_number();
						tok_line = cur_line;
						tok_col = cur_col;
						push_token(ctt_pkg::K_EOF, 8'h00, 32'd0);
						scan_state = SCAN_IDLE;
						cur_line = 16'd1;
						cur_col = 16'd1;
						tok_line = 16'd1;
						tok_col = 16'd1;
					end
				endcase
			end else begin
				case (scan_state)
					SCAN_COMMENT: begin
						if (c == "\n")
							scan_state = SCAN_IDLE_NB;
					end
					SCAN_NEWLINES: begin
						if (c != "\n") begin
							push_token(ctt_pkg::K_NL, 8'h00, 32'd0);
							start_token(c, 1'b0);
						end
					end
					SCAN_SYMBOL: begin
						if (is_letter(c) || is_digit(c) || c == "_" || c == "-") begin
							push_token(ctt_pkg::K_TEXT, c, 32'd0);
						end else begin
							push_token(ctt_pkg::K_TEND, 8'h00, 32'd0);
							start_token(c, 1'b0);
						end
					end
					SCAN_MINUS: begin
						if (is_digit(c)) begin
							num_acc = {24'd0, c - "0"};
							num_as_text = text_mode;
							if (num_as_text)
								push_token(ctt_pkg::K_TEXT, c, 32'd0);
							scan_state = SCAN_DIGITS;
						end else begin
							raise_error();
						end
					end
					SCAN_DIGITS: begin
						if (is_digit(c)) begin
							// magnitude saturates at 2^31
							wide = {32'd0, num_acc} * 64'd10 + {56'd0, c} - 64'd48;
							num_acc = (wide > 64'h8000_0000) ? 32'h8000_0000 : wide[31:0];
							if (num_as_text)
								push_token(ctt_pkg::K_TEXT, c, 32'd0);
						end else begin
							finish_number();
							start_token(c, 1'b0);
						end
					end
					SCAN_STRING: begin
						if (c == "\"") begin
							push_token(ctt_pkg::K_TEND, 8'h00, 32'd0);
							scan_state = SCAN_IDLE;
						end else begin
							push_token(ctt_pkg::K_TEXT, c, 32'd0);
						end
					end
					SCAN_BRACE: begin
						if (c == "{") begin
							push_token(ctt_pkg::K_OPEN, 8'h00, 32'd0);
							scan_state = SCAN_BODY;
						end else begin
							raise_error();
						end
					end
					SCAN_BODY: begin
						if (c == "}")
							scan_state = SCAN_BODY_BRACE;
						else
							push_token(ctt_pkg::K_TEXT, c, 32'd0);
					end
					SCAN_BODY_BRACE: begin
						if (c == "}") begin
							push_token(ctt_pkg::K_TEND, 8'h00, 32'd0);
							push_token(ctt_pkg::K_CLOSE, 8'h00, 32'd0);
							scan_state = SCAN_IDLE;
						end else begin
							push_token(ctt_pkg::K_TEXT, "}", 32'd0);
							push_token(ctt_pkg::K_TEXT, c, 32'd0);
							scan_state = SCAN_BODY;
						end
					end
					SCAN_IDLE_NB: start_token(c, 1'b1);
					default: start_token(c, 1'b0);
				endcase
				// position counters saturate
				if (c == "\n") begin
					cur_col = 16'd1;
					if (cur_line != POS_MAX)
						cur_line++;
				end else if (cur_col != POS_MAX) begin
					cur_col++;
				end
			end
		end
		if (step_count > 0) begin
			t = expected_tokens.pop_back();
			t.last = 1'b1;
			expected_tokens.push_back(t);
		end
	endtask

	// Stimulus helpers
	task automatic put_char(input logic [7:0] c);
		char_item_t it;
		it.ch = c;
		it.eoi = 1'b0;
		pending_chars.push_back(it);
		queued_items++;
	endtask

	task automatic put_end();
		char_item_t it;
		it.ch = 8'($urandom_range(0, 255));
		it.eoi = 1'b1;
		pending_chars.push_back(it);
		queued_items++;
		after_comment = 1'b0;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	function automatic logic [7:0] random_byte_except(input logic [7:0] banned);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == banned);
		return b;
	endfunction

	// One complete, error-free construct with random content
	task automatic put_random_token();
		int pick;
		int len;
		logic [7:0] b;
		logic [7:0] prev;
		pick = $urandom_range(0, 10);
		if (pick == 0 && after_comment)
			pick = 1;
		case (pick)
			0: repeat ($urandom_range(1, 2)) put_char($urandom_range(0, 1) ? " " : "\t");
			1: begin
				case ($urandom_range(0, 2))
					0: put_char("/");
					1: put_char("*");
					default: put_char(".");
				endcase
			end
			2: repeat ($urandom_range(1, 3)) put_char("\n");
			3: begin
				put_char("#");
				repeat ($urandom_range(0, 6)) put_char(random_byte_except("\n"));
				put_char("\n");
			end
			4, 5: begin
				put_char(sym_chars[$urandom_range(0, 51)]);
				repeat ($urandom_range(0, 6)) put_char(sym_chars[$urandom_range(0, 63)]);
			end
			6, 7: begin
				if ($urandom_range(0, 2) == 0)
					put_char("-");
				repeat ($urandom_range(1, 12)) put_char(8'("0" + $urandom_range(0, 9)));
			end
			8: begin
				put_char("\"");
				repeat ($urandom_range(0, 6)) put_char(random_byte_except("\""));
				put_char("\"");
			end
			9: begin
				// body never holds a brace pair and never ends on a brace
				put_text("{{");
				len = $urandom_range(0, 6);
				prev = 8'h00;
				for (int i = 0; i < len; i++) begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == "}" && (prev == "}" || i == len - 1));
					put_char(b);
					prev = b;
				end
				put_text("}}");
			end
			default: begin
				case ($urandom_range(0, 4))
					0: put_text("2147483647");
					1: put_text("2147483648");
					2: put_text("-2147483648");
					3: put_text("-2147483649");
					default: put_text("4294967296");
				endcase
			end
		endcase
		after_comment = (pick == 3);
	endtask

	task automatic set_text_mode(input bit mode);
		@(posedge clk);
		numbers_as_text_we <= 1'b1;
		numbers_as_text <= mode;
		text_mode = mode;
		@(posedge clk);
		numbers_as_text_we <= 1'b0;
	endtask

	// Drain all input, all results, then let the pipeline settle
	task automatic wait_quiet();
		while (pending_chars.size() != 0 || char_valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		mismatches++;
	endtask

	// Char channel driver; prediction at each accepted transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall)
				tokenize_step(char_byte, end_of_input);
			if (!char_valid || !char_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					char_valid <= 1'b0;
				end else if (pending_chars.size() != 0 && gaps_on
						&& $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 2);
					char_valid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					next_item = pending_chars.pop_front();
					char_valid <= 1'b1;
					char_byte <= next_item.ch;
					end_of_input <= next_item.eoi;
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// Token channel monitor with random stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (token_valid && !token_stall) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("unexpected token kind %0d at %0d:%0d",
						token_kind, token_line, token_column));
				end else begin
					exp_token = expected_tokens.pop_front();
					if (token_kind !== exp_token.kind || text_byte !== exp_token.tbyte
							|| int_value !== exp_token.value || token_line !== exp_token.line
							|| token_column !== exp_token.column || last !== exp_token.last)
						report_mismatch($sformatf(
							"got k%0d b%h v%0d %0d:%0d l%b, want k%0d b%h v%0d %0d:%0d l%b",
							token_kind, text_byte, int_value, token_line, token_column, last,
							exp_token.kind, exp_token.tbyte, exp_token.value, exp_token.line,
							exp_token.column, exp_token.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				token_stall <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				token_stall <= 1'b1;
			end else begin
				token_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (token_valid && !token_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		int start_count;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every token kind but the error, comment then symbol, negative number, string
		// with a newline, block body with a single close brace
		set_text_mode(1'b0);
		put_text("/*. #c\nx\n\n-7 42\"\n\"{{a}b}}");
		put_end();
		wait_quiet();

		// Directed digit text: negative, unterminated string, comment ended by end mark
		set_text_mode(1'b1);
		put_text("-5 12\"abc");
		put_end();
		put_text("#z");
		put_end();

		// Random phases, alternating the mode; one phase without idling
		for (int p = 0; p < 6; p++) begin
			wait_quiet();
			gaps_on = (p != 2);
			set_text_mode(p[0]);
			start_count = queued_items;
			while (queued_items - start_count < 28)
				put_random_token();
			case ($urandom_range(0, 3))
				0: begin
					put_char("\"");
					repeat ($urandom_range(0, 4)) put_char(random_byte_except("\""));
				end
				1: begin
					put_char("#");
					repeat ($urandom_range(0, 4)) put_char(random_byte_except("\n"));
				end
				default: ;
			endcase
			put_end();
		end

		// Last part: no idling, one error case, then items that must stay silent
		wait_quiet();
		gaps_on = 1'b0;
		set_text_mode(1'($urandom_range(0, 1)));
		start_count = queued_items;
		while (queued_items - start_count < 12)
			put_random_token();
		put_char(".");
		case ($urandom_range(0, 4))
			0: begin
				pick = $urandom_range(0, 4);
				put_char(pick == 0 ? 8'h00 : pick == 1 ? 8'h0D :
					pick == 2 ? 8'(8'h80 | $urandom_range(0, 127)) : pick == 3 ? "!" : "}");
			end
			1: begin
				put_text("#x\n");
				put_char($urandom_range(0, 1) ? " " : "\t");
			end
			2: begin
				put_char("-");
				if ($urandom_range(0, 1))
					put_char("a");
				else
					put_end();
			end
			3: begin
				put_char("{");
				if ($urandom_range(0, 1))
					put_char("x");
				else
					put_end();
			end
			default: begin
				if ($urandom_range(0, 1))
					put_text("{{ab}");
				else
					put_text("{{ab");
				put_end();
			end
		endcase
		repeat (6) put_char(8'($urandom_range(0, 255)));
		put_end();
		put_text("x.");
		put_end();

		wait_quiet();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ctt_pkg.sv
hw/rtl/ctt_front.sv
hw/rtl/ctt_queue.sv
hw/rtl/ctt_back.sv
hw/rtl/config_text_tokenizer_top.sv
tb/tb_config_text_tokenizer_top.sv
